>>> rtl/pmct_pkg.sv
package pmct_pkg;

  localparam int POS_W   = 13;
  localparam int BOUND_W = 14;
  localparam int SUM_W   = POS_W + 2;
  localparam int POS_LIM = 1 << POS_W;
  localparam int OUT_W   = 2 * POS_W + 3;
  localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_BOUND  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_BOUND = 1'd1;

  localparam logic [BOUND_W-1:0] WIDTH_BOUND_RST  = 14'd1280;
  localparam logic [BOUND_W-1:0] HEIGHT_BOUND_RST = 14'd800;
  localparam logic [POS_W-1:0]   POS_X_RST        = POS_W'(640);
  localparam logic [POS_W-1:0]   POS_Y_RST        = POS_W'(400);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_X_MOVE = 2'd1;
  localparam logic [1:0] PH_Y_MOVE = 2'd2;

  localparam int HDR_ALWAYS_ONE = 3;
  localparam int HDR_X_SIGN     = 4;
  localparam int HDR_Y_SIGN     = 5;

  typedef struct packed {
    logic [1:0]       phase;
    logic [7:0]       header_byte;
    logic [7:0]       x_move_byte;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [2:0]       buttons;
  } track_state_t;

  typedef struct packed {
    logic             packet_done;
    logic [2:0]       buttons;
    logic [POS_W-1:0] cursor_y;
    logic [POS_W-1:0] cursor_x;
  } track_result_t;

  function automatic logic [POS_W-1:0] clamp_axis(input logic signed [SUM_W-1:0] v,
                                                  input logic [BOUND_W-1:0] b);
    logic [POS_W-1:0] hi;
    if (32'(b) > 32'(POS_LIM)) begin
      hi = POS_W'(POS_LIM - 1);
    end else if (b == '0) begin
      hi = '0;
    end else begin
      hi = POS_W'(b - 1'b1);
    end
    if (v < 0) begin
      clamp_axis = '0;
    end else if (v > $signed({2'b00, hi})) begin
      clamp_axis = hi;
    end else begin
      clamp_axis = POS_W'(v);
    end
  endfunction

endpackage

>>> rtl/pmct_step.sv
module pmct_step (
  input  pmct_pkg::track_state_t        cur,
  input  logic [7:0]                    rx_byte,
  input  logic                          from_aux,
  input  logic [pmct_pkg::BOUND_W-1:0]  width_bound,
  input  logic [pmct_pkg::BOUND_W-1:0]  height_bound,
  output pmct_pkg::track_state_t        nxt,
  output pmct_pkg::track_result_t       res
);

  logic signed [pmct_pkg::SUM_W-1:0] dx;
  logic signed [pmct_pkg::SUM_W-1:0] dy;
  logic signed [pmct_pkg::SUM_W-1:0] sum_x;
  logic signed [pmct_pkg::SUM_W-1:0] sum_y;
  logic                               done;

  assign dx = {{(pmct_pkg::SUM_W-8){cur.header_byte[pmct_pkg::HDR_X_SIGN]}}, cur.x_move_byte};
  assign dy = {{(pmct_pkg::SUM_W-8){cur.header_byte[pmct_pkg::HDR_Y_SIGN]}}, rx_byte};
  assign sum_x = $signed({2'b00, cur.pos_x}) + dx;
  assign sum_y = $signed({2'b00, cur.pos_y}) - dy;

  always_comb begin
    nxt  = cur;
    done = 1'b0;
    if (from_aux) begin
      unique case (cur.phase)
        pmct_pkg::PH_X_MOVE: begin
          nxt.x_move_byte = rx_byte;
          nxt.phase       = pmct_pkg::PH_Y_MOVE;
        end
        pmct_pkg::PH_Y_MOVE: begin
          nxt.buttons = cur.header_byte[2:0];
          nxt.pos_x   = pmct_pkg::clamp_axis(sum_x, width_bound);
          nxt.pos_y   = pmct_pkg::clamp_axis(sum_y, height_bound);
          nxt.phase   = pmct_pkg::PH_HEADER;
          done        = 1'b1;
        end
        default: begin
          if (rx_byte[pmct_pkg::HDR_ALWAYS_ONE]) begin
            nxt.header_byte = rx_byte;
            nxt.phase       = pmct_pkg::PH_X_MOVE;
          end else begin
            nxt.phase = pmct_pkg::PH_HEADER;
          end
        end
      endcase
    end
  end

  always_comb begin
    res.cursor_x    = nxt.pos_x;
    res.cursor_y    = nxt.pos_y;
    res.buttons     = nxt.buttons;
    res.packet_done = done;
  end

endmodule

>>> rtl/ps2_mouse_packet_cursor_tracker.sv
// Channel   Direction  tdata                       tuser
// s_axis    in         rx_byte                     from_aux
// m_axis    out        cursor_x, cursor_y,         packet_done
//                      left, right, middle (pressed)
// cfg       in         width_bound (index 0), height_bound (index 1) on cfg_data
//
// Each beat passes an input register, then the decode and cursor update into the
// output register. One beat per cycle is sustained while m_axis_tready stays high;
// the cursor/packet state is updated as a beat leaves the input register.
// rst is synchronous: cursor returns to 640/400, bounds to 1280/800, packet restarts.
// A stalled output holds its beat; the input register still fills behind it.
module ps2_mouse_packet_cursor_tracker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] rx_byte
  input  logic                              s_axis_tuser,  // [0] from_aux
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [12:0] cursor_x, [25:13] cursor_y, [26] left_pressed, [27] right_pressed,
  // [28] middle_pressed, rest zero
  output logic [pmct_pkg::TDATA_W-1:0]      m_axis_tdata,
  output logic                              m_axis_tuser,  // [0] packet_done
  input  logic                              cfg_we,
  input  logic [pmct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmct_pkg::BOUND_W-1:0]      cfg_data
);

  logic [pmct_pkg::BOUND_W-1:0] width_bound;
  logic [pmct_pkg::BOUND_W-1:0] height_bound;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_aux;

  logic                    out_valid;
  pmct_pkg::track_result_t out_res;

  pmct_pkg::track_state_t  state;
  pmct_pkg::track_state_t  state_next;
  pmct_pkg::track_result_t res_next;

  logic advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_bound  <= pmct_pkg::WIDTH_BOUND_RST;
      height_bound <= pmct_pkg::HEIGHT_BOUND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pmct_pkg::REG_WIDTH_BOUND:  width_bound  <= cfg_data;
        pmct_pkg::REG_HEIGHT_BOUND: height_bound <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_aux  <= s_axis_tuser;
    end
  end

  pmct_step u_step (
    .cur          (state),
    .rx_byte      (in_byte),
    .from_aux     (in_aux),
    .width_bound  (width_bound),
    .height_bound (height_bound),
    .nxt          (state_next),
    .res          (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= pmct_pkg::PH_HEADER;
      state.header_byte <= '0;
      state.x_move_byte <= '0;
      state.pos_x       <= pmct_pkg::POS_X_RST;
      state.pos_y       <= pmct_pkg::POS_Y_RST;
      state.buttons     <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = pmct_pkg::TDATA_W'({out_res.buttons, out_res.cursor_y, out_res.cursor_x});
  assign m_axis_tuser  = out_res.packet_done;

endmodule

>>> rtl/pmct_checker.sv
module pmct_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pmct_pkg::TDATA_W-1:0]  m_axis_tdata,
  input logic                          m_axis_tuser
);

  localparam int BTN_LO = 2 * pmct_pkg::POS_W;

  logic       out_beat;
  logic       last_done;
  logic [2:0] last_buttons;

  assign out_beat = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_done    <= 1'b0;
      last_buttons <= '0;
    end else if (out_beat) begin
      last_done    <= m_axis_tuser;
      last_buttons <= m_axis_tdata[BTN_LO +: 3];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with output register empty");

  a_done_spacing: assert property (@(posedge clk) disable iff (rst)
    out_beat && m_axis_tuser |-> !last_done)
    else $error("two packets completed on consecutive beats");

  a_buttons_steady: assert property (@(posedge clk) disable iff (rst)
    out_beat && !m_axis_tuser |-> m_axis_tdata[BTN_LO +: 3] == last_buttons)
    else $error("buttons changed without a completed packet");

endmodule

bind ps2_mouse_packet_cursor_tracker pmct_checker u_pmct_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> bench/ps2_mouse_packet_cursor_tracker_tb.sv
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_tracker_tb;

  localparam int IDLE_LIMIT = 2000;
  localparam int ITEM_TARGET = 1100;
  localparam int PHASE_ITEMS = 200;

  typedef struct packed {
    logic                                         done;
    logic [pmct_pkg::TDATA_W-pmct_pkg::OUT_W-1:0] pad;
    logic                                         middle;
    logic                                         right;
    logic                                         left;
    logic [pmct_pkg::POS_W-1:0]                   y;
    logic [pmct_pkg::POS_W-1:0]                   x;
  } cursor_beat_t;

  typedef struct {
    logic                           is_reg;
    logic [pmct_pkg::CFG_IDX_W-1:0] idx;
    logic [pmct_pkg::BOUND_W-1:0]   val;
    logic [7:0]                     b;
    logic                           aux;
  } stim_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata = '0;
  logic                           s_axis_tuser = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [pmct_pkg::TDATA_W-1:0]   m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           cfg_we = 1'b0;
  logic [pmct_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pmct_pkg::BOUND_W-1:0]   cfg_data = '0;

  stim_t        pend_q[$];
  cursor_beat_t cursor_q[$];

  int   sent_cnt = 0;
  int   got_cnt = 0;
  int   err_cnt = 0;
  int   live_items = 0;
  int   cyc = 0;
  int   idle_cyc = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  logic drv_calm = 1'b0;
  logic mon_calm = 1'b0;
  logic tail_mode = 1'b0;
  logic all_issued = 1'b0;

  logic [1:0]                   trk_phase;
  logic [7:0]                   trk_hdr;
  logic [7:0]                   trk_xbyte;
  logic [pmct_pkg::POS_W-1:0]   trk_x;
  logic [pmct_pkg::POS_W-1:0]   trk_y;
  logic [2:0]                   trk_btn;
  logic [pmct_pkg::BOUND_W-1:0] bnd_w;
  logic [pmct_pkg::BOUND_W-1:0] bnd_h;

  ps2_mouse_packet_cursor_tracker u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void flag_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic logic [pmct_pkg::POS_W-1:0] clip_axis(int v,
                                                           logic [pmct_pkg::BOUND_W-1:0] bound);
    int top;
    if (bound == '0) begin
      top = 0;
    end else if (int'(bound) > pmct_pkg::POS_LIM) begin
      top = pmct_pkg::POS_LIM - 1;
    end else begin
      top = int'(bound) - 1;
    end
    if (v < 0) v = 0;
    if (v > top) v = top;
    return pmct_pkg::POS_W'(v);
  endfunction

  task automatic track_byte(input logic [7:0] b, input logic aux, output cursor_beat_t r);
    int dx;
    int dy;
    r = '0;
    if (aux) begin
      case (trk_phase)
        pmct_pkg::PH_X_MOVE: begin
          trk_xbyte = b;
          trk_phase = pmct_pkg::PH_Y_MOVE;
        end
        pmct_pkg::PH_Y_MOVE: begin
          dx = int'(trk_xbyte) - (trk_hdr[pmct_pkg::HDR_X_SIGN] ? 256 : 0);
          dy = int'(b) - (trk_hdr[pmct_pkg::HDR_Y_SIGN] ? 256 : 0);
          trk_btn = trk_hdr[2:0];
          trk_x = clip_axis(int'(trk_x) + dx, bnd_w);
          trk_y = clip_axis(int'(trk_y) - dy, bnd_h);
          trk_phase = pmct_pkg::PH_HEADER;
          r.done = 1'b1;
        end
        default: begin
          if (b[pmct_pkg::HDR_ALWAYS_ONE]) begin
            trk_hdr = b;
            trk_phase = pmct_pkg::PH_X_MOVE;
          end else begin
            trk_phase = pmct_pkg::PH_HEADER;
          end
        end
      endcase
    end
    r.x = trk_x;
    r.y = trk_y;
    r.left = trk_btn[0];
    r.right = trk_btn[1];
    r.middle = trk_btn[2];
  endtask

  function automatic void add_byte(logic [7:0] b, logic aux);
    stim_t s;
    s = '{is_reg: 1'b0, idx: '0, val: '0, b: b, aux: aux};
    pend_q.push_back(s);
    if (aux) live_items++;
  endfunction

  function automatic void add_reg(logic [pmct_pkg::CFG_IDX_W-1:0] idx,
                                  logic [pmct_pkg::BOUND_W-1:0] val);
    stim_t s;
    s = '{is_reg: 1'b1, idx: idx, val: val, b: '0, aux: 1'b0};
    pend_q.push_back(s);
  endfunction

  function automatic void add_packet(logic [7:0] hdr, logic [7:0] xb, logic [7:0] yb);
    hdr[pmct_pkg::HDR_ALWAYS_ONE] = 1'b1;
    add_byte(hdr, 1'b1);
    add_byte(xb, 1'b1);
    add_byte(yb, 1'b1);
  endfunction

  function automatic logic [pmct_pkg::BOUND_W-1:0] pick_bound();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return pmct_pkg::BOUND_W'(1);
      2: return pmct_pkg::BOUND_W'(pmct_pkg::POS_LIM);
      3: return '1;
      4: return pmct_pkg::BOUND_W'(pmct_pkg::POS_LIM + 1);
      5: return pmct_pkg::BOUND_W'($urandom_range(1, 64));
      6: return pmct_pkg::BOUND_W'($urandom_range(1, pmct_pkg::POS_LIM));
      default: return pmct_pkg::BOUND_W'($urandom_range(600, 2000));
    endcase
  endfunction

  always @(posedge clk) begin : drive_proc
    logic  fire;
    logic  nv;
    logic  nwe;
    stim_t head;
    fire = s_axis_tvalid && s_axis_tready;
    nv = s_axis_tvalid && !fire;
    nwe = 1'b0;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      if (fire) sent_cnt <= sent_cnt + 1;
      if (cyc % 64 == 0) drv_calm = ($urandom_range(0, 3) == 0);
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pend_q.size() > 0) begin
          head = pend_q[0];
          if (head.is_reg) begin
            // hold register writes until the block has drained
            if (!s_axis_tvalid && sent_cnt == got_cnt) begin
              void'(pend_q.pop_front());
              nwe = 1'b1;
              cfg_index <= head.idx;
              cfg_data <= head.val;
            end
          end else if (!tail_mode && !drv_calm && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 7);
          end else begin
            void'(pend_q.pop_front());
            nv = 1'b1;
            s_axis_tdata <= head.b;
            s_axis_tuser <= head.aux;
          end
        end
      end
      s_axis_tvalid <= nv;
      cfg_we <= nwe;
      tail_mode <= (pend_q.size() < 120);
      all_issued <= (pend_q.size() == 0) && !nv;
    end
  end

  always @(posedge clk) begin : watch_proc
    cursor_beat_t got;
    cursor_beat_t want;
    logic         nr;
    if (rst) begin
      trk_phase = pmct_pkg::PH_HEADER;
      trk_hdr = '0;
      trk_xbyte = '0;
      trk_x = pmct_pkg::POS_X_RST;
      trk_y = pmct_pkg::POS_Y_RST;
      trk_btn = '0;
      bnd_w = pmct_pkg::WIDTH_BOUND_RST;
      bnd_h = pmct_pkg::HEIGHT_BOUND_RST;
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = cursor_beat_t'({m_axis_tuser, m_axis_tdata});
        got_cnt <= got_cnt + 1;
        if (cursor_q.size() == 0) begin
          flag_error($sformatf("unexpected beat x=%0d y=%0d btn=%b%b%b done=%b",
                               got.x, got.y, got.middle, got.right, got.left, got.done));
        end else begin
          want = cursor_q.pop_front();
          if (got != want) begin
            flag_error($sformatf({"mismatch exp x=%0d y=%0d l=%b r=%b m=%b done=%b pad=%0h",
                                  " got x=%0d y=%0d l=%b r=%b m=%b done=%b pad=%0h"},
                                 want.x, want.y, want.left, want.right, want.middle,
                                 want.done, want.pad, got.x, got.y, got.left, got.right,
                                 got.middle, got.done, got.pad));
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == pmct_pkg::REG_WIDTH_BOUND) bnd_w = cfg_data;
        else if (cfg_index == pmct_pkg::REG_HEIGHT_BOUND) bnd_h = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        track_byte(s_axis_tdata, s_axis_tuser, want);
        cursor_q.push_back(want);
      end
      if (cyc % 64 == 32) mon_calm = ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
        stall_left--;
        nr = 1'b0;
      end else if (!tail_mode && !mon_calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 7);
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
      m_axis_tready <= nr;
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cyc <= 0;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
    if (idle_cyc >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stim_proc
    int k;
    int next_cfg;
    logic [7:0] hdr;

    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b1);
    add_byte(8'hF7, 1'b1);
    add_packet(8'h0F, 8'hFF, 8'h00);
    add_packet(8'h38, 8'h00, 8'h00);
    add_byte(8'h09, 1'b1);
    add_byte(8'h55, 1'b0);
    add_byte(8'h7F, 1'b1);
    add_byte(8'h80, 1'b1);
    add_packet(8'hFF, 8'h80, 8'h7F);
    add_reg(pmct_pkg::REG_WIDTH_BOUND, pmct_pkg::BOUND_W'(1));
    add_reg(pmct_pkg::REG_HEIGHT_BOUND, pmct_pkg::BOUND_W'(pmct_pkg::POS_LIM));
    add_packet(8'h08, 8'h7F, 8'h80);
    add_reg(pmct_pkg::REG_WIDTH_BOUND, '1);
    add_reg(pmct_pkg::REG_HEIGHT_BOUND, '0);
    add_packet(8'h28, 8'hFF, 8'hFF);
    add_packet(8'h08, 8'hFF, 8'h00);
    add_reg(pmct_pkg::REG_WIDTH_BOUND, pmct_pkg::BOUND_W'(8));
    add_byte(8'h00, 1'b0);
    add_packet(8'h08, 8'h00, 8'h00);

    next_cfg = live_items;
    while (live_items < ITEM_TARGET) begin
      if (live_items >= next_cfg) begin
        add_reg(pmct_pkg::REG_WIDTH_BOUND, pick_bound());
        add_reg(pmct_pkg::REG_HEIGHT_BOUND, pick_bound());
        next_cfg = live_items + PHASE_ITEMS;
      end
      hdr = 8'($urandom);
      if ($urandom_range(0, 9) < 8) begin
        add_packet(hdr, 8'($urandom), 8'($urandom));
      end else begin
        k = $urandom_range(0, 3);
        case (k)
          0: add_byte(8'($urandom), 1'($urandom));
          1: begin
            hdr[pmct_pkg::HDR_ALWAYS_ONE] = 1'b0;
            add_byte(hdr, 1'b1);
          end
          2: begin
            hdr[pmct_pkg::HDR_ALWAYS_ONE] = 1'b1;
            add_byte(hdr, 1'b1);
            add_byte(8'($urandom), 1'b1);
            add_byte(8'($urandom), 1'b0);
            add_byte(8'($urandom), 1'b1);
          end
          default: begin
            hdr[pmct_pkg::HDR_ALWAYS_ONE] = 1'b1;
            add_byte(hdr, 1'b1);
            add_byte(8'($urandom), 1'b1);
          end
        endcase
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!(all_issued && sent_cnt == got_cnt)) @(posedge clk);
    repeat (8) @(posedge clk);
    if (cursor_q.size() != 0) begin
      flag_error($sformatf("%0d expected beats never arrived", cursor_q.size()));
    end
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
